FILE: hdl/prc_pkg.sv
package prc_pkg;

    localparam int DEF_MAX_POLYGONS = 64;
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_COORD_BITS   = 32;
    localparam int REGION_BITS      = 7;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_CLOSE  = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef struct packed {
        logic done;
        logic toggle;
    } t_edge_rsp;

endpackage

FILE: hdl/prc_vstore.sv
module prc_vstore #(
    parameter int DEPTH = prc_pkg::DEF_MAX_VERTICES,
    parameter int CW    = prc_pkg::DEF_COORD_BITS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [CW-1:0] i_wx,
    input  logic signed [CW-1:0] i_wy,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [CW-1:0] o_rx,
    output logic signed [CW-1:0] o_ry
);
    import prc_pkg::*;

    logic signed [CW-1:0] mem_x [DEPTH];
    logic signed [CW-1:0] mem_y [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_x[i_waddr] <= i_wx;
            mem_y[i_waddr] <= i_wy;
        end
        o_rx <= mem_x[i_raddr];
        o_ry <= mem_y[i_raddr];
    end

endmodule

FILE: hdl/prc_edge.sv
module prc_edge #(
    parameter int CW = prc_pkg::DEF_COORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [CW-1:0] i_tx,
    input  logic signed [CW-1:0] i_ty,
    input  logic signed [CW-1:0] i_xi,
    input  logic signed [CW-1:0] i_yi,
    input  logic signed [CW-1:0] i_xj,
    input  logic signed [CW-1:0] i_yj,
    output prc_pkg::t_edge_rsp   o_rsp
);
    import prc_pkg::*;

    localparam int W  = CW + 1;
    localparam int AW = 2 * W + 1;
    localparam int KW = $clog2(W + 1);

    logic [W-1:0]         r_a;
    logic [W-1:0]         r_b;
    logic signed [AW-1:0] r_mdx;
    logic signed [AW-1:0] r_mdy;
    logic signed [AW-1:0] r_acc;
    logic [KW-1:0]        r_k;
    logic                 r_busy;
    logic                 r_s_pos;
    logic                 r_e_pos;
    logic                 r_e_neg;

    logic signed [W-1:0]  dx;
    logic signed [W-1:0]  dy;
    logic signed [W:0]    e;
    logic                 last;
    logic signed [AW-1:0] tx_term;
    logic signed [AW-1:0] ty_term;
    logic                 d_neg;
    logic                 d_zero;
    logic                 d_lt;

    assign dx = W'(i_xj) - W'(i_xi);
    assign dy = W'(i_yj) - W'(i_yi);
    assign e  = (W + 1)'(dy) - (W + 1)'(dx);
    assign last = (r_k == KW'(W - 1));

    always_comb begin
        tx_term = '0;
        ty_term = '0;
        if (r_a[0]) begin
            tx_term = last ? -r_mdx : r_mdx;
        end
        if (r_b[0]) begin
            ty_term = last ? -r_mdy : r_mdy;
        end
    end

    // Advance one bit of each multiplier per cycle: acc = a*dx - b*dy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_k     <= '0;
            r_a     <= W'(i_ty) - W'(i_yi);
            r_b     <= W'(i_tx) - W'(i_xi);
            r_mdx   <= AW'(dx);
            r_mdy   <= AW'(dy);
            r_acc   <= '0;
            r_s_pos <= (dy > 0);
            r_e_pos <= (e > 0);
            r_e_neg <= e[W];
        end else if (r_busy) begin
            if (r_k == KW'(W)) begin
                r_busy <= 1'b0;
            end else begin
                r_acc <= r_acc + tx_term - ty_term;
                r_mdx <= r_mdx <<< 1;
                r_mdy <= r_mdy <<< 1;
                r_a   <= r_a >> 1;
                r_b   <= r_b >> 1;
                r_k   <= r_k + 1'b1;
            end
        end
    end

    assign d_neg  = r_acc[AW-1];
    assign d_zero = (r_acc == '0);
    assign d_lt   = r_s_pos ? d_neg : (!d_neg && !d_zero);

    assign o_rsp.done   = r_busy && (r_k == KW'(W));
    assign o_rsp.toggle = d_lt || (d_zero && (r_s_pos ? r_e_pos : r_e_neg));

endmodule

FILE: hdl/polygon_region_classifier.sv
// Polygon region classifier. Load polygons with append-vertex items and
// close each one with a close item; clear empties the table. A query
// returns the index of the first closed polygon that holds the point under
// even-odd ray casting, or the polygon count plus one when none does.
// Every item gives one result transfer, and the input stalls while a query
// runs and while a result waits. A query visits the polygons in turn until
// one holds the point and walks the edges of each; every edge whose y span
// straddles the point runs the crossing test, a bit-serial exact product
// compare, and edge vertices come one at a time from the single read port
// of the vertex memory. Appends and closes beyond the store limits are
// dropped with status 1.
module polygon_region_classifier #(
    parameter int MAX_POLYGONS = prc_pkg::DEF_MAX_POLYGONS,
    parameter int MAX_VERTICES = prc_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = prc_pkg::DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [prc_pkg::REGION_BITS-1:0] o_region_index,
    output logic                         o_found,
    output logic                         o_status
);
    import prc_pkg::*;

    localparam int VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VC = $clog2(MAX_VERTICES + 1);
    localparam int PA = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
    localparam int PC = $clog2(MAX_POLYGONS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_POLY, ST_END, ST_J, ST_I, ST_MUL, ST_ADV
    } t_state;

    t_state r_state;

    logic [VC-1:0] r_vcount;
    logic [PC-1:0] r_pcount;
    logic [PC-1:0] r_g;
    logic [VC-1:0] r_start;
    logic [VC-1:0] r_end;
    logic [VC-1:0] r_i;
    logic          r_odd;

    logic signed [COORD_BITS-1:0] r_tx;
    logic signed [COORD_BITS-1:0] r_ty;
    logic signed [COORD_BITS-1:0] r_xi;
    logic signed [COORD_BITS-1:0] r_yi;
    logic signed [COORD_BITS-1:0] r_xj;
    logic signed [COORD_BITS-1:0] r_yj;

    logic [VC-1:0] end_mem [MAX_POLYGONS];
    logic [VC-1:0] r_end_rd;

    logic          accept;
    logic          v_full;
    logic          p_full;
    logic          vs_we;
    logic          result_load;
    logic [VA-1:0] rd_addr;
    logic [VC-1:0] rd_idx;
    logic [VC-1:0] i_next;
    logic          straddle;
    logic          edge_start;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic [PC:0]   miss_region;
    t_edge_rsp     edge_rsp;

    assign o_in_stall = (r_state != ST_IDLE) || (o_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign p_full     = (r_pcount >= PC'(MAX_POLYGONS));
    assign v_full     = (r_vcount >= VC'(MAX_VERTICES));
    assign vs_we      = accept && (t_action'(i_action) == ACT_APPEND) && !v_full && !p_full;
    assign i_next     = r_i + 1'b1;
    assign miss_region = (PC + 1)'(r_pcount) + 1'b1;

    // A result is loaded on a non-query transfer, on a miss and on a hit.
    assign result_load = ((r_state == ST_IDLE) && accept && (t_action'(i_action) != ACT_QUERY))
                      || ((r_state == ST_POLY) && (r_g == r_pcount))
                      || ((r_state == ST_ADV) && (i_next == r_end) && r_odd);

    // Pick the vertex to fetch: the closing vertex, the first, the next, or else the current one.
    always_comb begin
        case (r_state)
            ST_END:  rd_idx = r_end_rd - 1'b1;
            ST_J:    rd_idx = r_start;
            ST_ADV:  rd_idx = i_next;
            default: rd_idx = r_i;
        endcase
    end
    assign rd_addr = rd_idx[VA-1:0];

    assign straddle = ((vy <= r_ty) && (r_yj > r_ty)) || ((r_yj <= r_ty) && (vy > r_ty));
    assign edge_start = (r_state == ST_I) && straddle;

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && accept && (t_action'(i_action) == ACT_CLOSE) && !p_full) begin
            end_mem[r_pcount[PA-1:0]] <= r_vcount;
        end
        r_end_rd <= end_mem[r_g[PA-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vcount    <= '0;
            r_pcount    <= '0;
            r_start     <= '0;
            r_g         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (result_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                // Drop the result once the downstream side takes the transfer.
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        o_region_index <= '0;
                        o_found        <= 1'b0;
                        case (t_action'(i_action))
                            ACT_CLEAR: begin
                                r_vcount <= '0;
                                r_pcount <= '0;
                                o_status <= 1'b0;
                            end
                            ACT_APPEND: begin
                                o_status <= v_full || p_full;
                                if (!(v_full || p_full)) begin
                                    r_vcount <= r_vcount + 1'b1;
                                end
                            end
                            ACT_CLOSE: begin
                                o_status <= p_full;
                                if (!p_full) begin
                                    r_pcount <= r_pcount + 1'b1;
                                end
                            end
                            default: begin
                                o_status <= 1'b0;
                                r_tx     <= i_coord_x;
                                r_ty     <= i_coord_y;
                                r_g      <= '0;
                                r_start  <= '0;
                                r_state  <= ST_POLY;
                            end
                        endcase
                    end
                end
                ST_POLY: begin
                    if (r_g == r_pcount) begin
                        o_region_index <= REGION_BITS'(miss_region);
                        o_found        <= 1'b0;
                        r_state        <= ST_IDLE;
                    end else begin
                        r_state <= ST_END;
                    end
                end
                ST_END: begin
                    r_end <= r_end_rd;
                    r_odd <= 1'b0;
                    if (r_end_rd <= r_start) begin
                        // Empty polygon holds no point: skip it.
                        r_start <= r_end_rd;
                        r_g     <= r_g + 1'b1;
                        r_state <= ST_POLY;
                    end else begin
                        r_state <= ST_J;
                    end
                end
                ST_J: begin
                    r_xj    <= vx;
                    r_yj    <= vy;
                    r_i     <= r_start;
                    r_state <= ST_I;
                end
                ST_I: begin
                    r_xi    <= vx;
                    r_yi    <= vy;
                    r_state <= straddle ? ST_MUL : ST_ADV;
                end
                ST_MUL: begin
                    if (edge_rsp.done) begin
                        r_odd   <= r_odd ^ edge_rsp.toggle;
                        r_state <= ST_ADV;
                    end
                end
                ST_ADV: begin
                    r_xj <= r_xi;
                    r_yj <= r_yi;
                    if (i_next == r_end) begin
                        if (r_odd) begin
                            o_region_index <= REGION_BITS'(r_g);
                            o_found        <= 1'b1;
                            r_state        <= ST_IDLE;
                        end else begin
                            r_start <= r_end;
                            r_g     <= r_g + 1'b1;
                            r_state <= ST_POLY;
                        end
                    end else begin
                        r_i     <= i_next;
                        r_state <= ST_I;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    prc_vstore #(
        .DEPTH (MAX_VERTICES),
        .CW    (COORD_BITS),
        .AW    (VA)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_we    (vs_we),
        .i_waddr (r_vcount[VA-1:0]),
        .i_wx    (i_coord_x),
        .i_wy    (i_coord_y),
        .i_raddr (rd_addr),
        .o_rx    (vx),
        .o_ry    (vy)
    );

    prc_edge #(
        .CW (COORD_BITS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (edge_start),
        .i_tx    (r_tx),
        .i_ty    (r_ty),
        .i_xi    (vx),
        .i_yi    (vy),
        .i_xj    (r_xj),
        .i_yj    (r_yj),
        .o_rsp   (edge_rsp)
    );

endmodule
